FILE: hdl/cfd_pkg.sv
// ----------------------------------------------------------------------------
// cfd_pkg: shared types and constants for the serial frame deframer
// Frame bytes, window sizing and the result record.
// ----------------------------------------------------------------------------
package cfd_pkg;

	localparam int WIN_DEPTH = 17;                  // bytes held by the search window
	localparam int RAM_DEPTH = 32;                  // circular store, power of two
	localparam int PTR_W     = $clog2(RAM_DEPTH);
	localparam int CNT_W     = $clog2(WIN_DEPTH + 1);
	localparam int OFF_W     = PTR_W + 1;           // offsets plus frame length
	localparam int TDATA_W   = 80;

	localparam logic [7:0] HDR0       = 8'h41;
	localparam logic [7:0] HDR1       = 8'h54;
	localparam logic [7:0] TAIL0      = 8'h0D;
	localparam logic [7:0] TAIL1      = 8'h0A;
	localparam logic [7:0] ID_REJECT  = 8'h04;
	localparam logic [7:0] MAX_DLC    = 8'd8;
	localparam logic [3:0] FRAME_OVHD = 4'd9;        // header, id, length, tail

	typedef struct packed {
		logic [7:0][7:0] data;
		logic [3:0]      data_length;
		logic [10:0]     can_id;
	} result_t;

endpackage

FILE: hdl/cfd_ram.sv
// ----------------------------------------------------------------------------
// cfd_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module cfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/cfd_out.sv
// ----------------------------------------------------------------------------
// cfd_out: result output register
// Holds one decoded frame until the downstream side takes it.
// ----------------------------------------------------------------------------
module cfd_out (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  cfd_pkg::result_t              result,
	output logic                          out_free,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [cfd_pkg::TDATA_W-1:0]   m_tdata
);

	logic             valid_q;
	cfd_pkg::result_t result_q;

	assign out_free = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata  = {1'b0, result_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push && out_free) begin
			result_q <= result;
		end
	end

endmodule

FILE: hdl/cfd_scanner.sv
// ----------------------------------------------------------------------------
// cfd_scanner: window store sequencer
// Appends bytes to a circular window in RAM and walks it one byte per cycle
// for the first complete, waiting or lone candidate; a busy output holds it.
// ----------------------------------------------------------------------------
module cfd_scanner (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,
	input  logic                out_free,
	output logic                push,
	output cfd_pkg::result_t    result
);

	typedef enum logic [3:0] {
		IDLE, START, H0, H1, ID, LEN, T0, T1, C2, C3, DAT, EMIT
	} state_t;

	localparam logic [cfd_pkg::CNT_W-1:0] WIN_FULL = cfd_pkg::CNT_W'(cfd_pkg::WIN_DEPTH);

	state_t                        state_q, state_d;
	logic [cfd_pkg::PTR_W-1:0]     head_q, head_d;
	logic [cfd_pkg::CNT_W-1:0]     count_q, count_d;
	logic [cfd_pkg::PTR_W-1:0]     i_q, i_d;
	logic [cfd_pkg::PTR_W-1:0]     fl_q, fl_d;
	logic [3:0]                    dlc_q, dlc_d;
	logic [2:0]                    k_q, k_d;
	logic [7:0]                    id_hi_q, id_hi_d;
	logic [10:0]                   can_id_q, can_id_d;
	logic [7:0][7:0]               data_q, data_d;

	logic                          we;
	logic [cfd_pkg::PTR_W-1:0]     waddr;
	logic [cfd_pkg::OFF_W-1:0]     rd_off;
	logic [cfd_pkg::PTR_W-1:0]     raddr;
	logic [7:0]                    rd_data;
	logic                          adv, fin;

	logic [cfd_pkg::OFF_W-1:0]     i6, n6, end6, fl_new;

	assign i6     = {1'b0, i_q};
	assign n6     = cfd_pkg::OFF_W'(count_q);
	assign end6   = i6 + cfd_pkg::OFF_W'(fl_q);
	assign fl_new = cfd_pkg::OFF_W'(cfd_pkg::FRAME_OVHD) + cfd_pkg::OFF_W'(rd_data[3:0]);
	assign raddr  = head_q + rd_off[cfd_pkg::PTR_W-1:0];

	assign s_tready = (state_q == IDLE);

	assign result = {data_q, dlc_q, can_id_q};

	cfd_ram #(
		.WIDTH(8),
		.DEPTH(cfd_pkg::RAM_DEPTH)
	) u_win (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(s_tdata),
		.raddr(raddr),
		.rdata(rd_data)
	);

	always_comb begin
		state_d  = state_q;
		head_d   = head_q;
		count_d  = count_q;
		i_d      = i_q;
		fl_d     = fl_q;
		dlc_d    = dlc_q;
		k_d      = k_q;
		id_hi_d  = id_hi_q;
		can_id_d = can_id_q;
		data_d   = data_q;
		we       = 1'b0;
		waddr    = head_q + cfd_pkg::PTR_W'(count_q);
		rd_off   = '0;
		push     = 1'b0;
		adv      = 1'b0;
		fin      = 1'b0;

		unique case (state_q)
			IDLE: begin
				if (s_tvalid) begin
					we  = 1'b1;
					i_d = '0;
					if (count_q == WIN_FULL) begin
						head_d = head_q + 1'b1;     // never reached at this depth
					end else begin
						count_d = count_q + 1'b1;
					end
					state_d = START;
				end
			end
			START: begin
				rd_off  = i6;
				state_d = H0;
			end
			H0: begin
				if (rd_data == cfd_pkg::HDR0) begin
					if (i6 + 1'b1 >= n6) begin
						fin = 1'b1;                 // lone header byte at the end
					end else begin
						rd_off  = i6 + 1'b1;
						state_d = H1;
					end
				end else if (i6 + 1'b1 >= n6) begin
					count_d = '0;
					state_d = IDLE;
				end else begin
					adv = 1'b1;
				end
			end
			H1: begin
				if (rd_data != cfd_pkg::HDR1) begin
					adv = 1'b1;
				end else if (i6 + 6'd8 >= n6) begin
					fin = 1'b1;
				end else begin
					rd_off  = i6 + 6'd5;
					state_d = ID;
				end
			end
			ID: begin
				if ((rd_data & cfd_pkg::ID_REJECT) != 8'd0) begin
					adv = 1'b1;
				end else begin
					rd_off  = i6 + 6'd6;
					state_d = LEN;
				end
			end
			LEN: begin
				if (rd_data > cfd_pkg::MAX_DLC) begin
					adv = 1'b1;
				end else if (i6 + fl_new > n6) begin
					fin = 1'b1;
				end else begin
					fl_d    = fl_new[cfd_pkg::PTR_W-1:0];
					dlc_d   = rd_data[3:0];
					rd_off  = i6 + fl_new - 6'd2;
					state_d = T0;
				end
			end
			T0: begin
				if (rd_data != cfd_pkg::TAIL0) begin
					adv = 1'b1;
				end else begin
					rd_off  = end6 - 6'd1;
					state_d = T1;
				end
			end
			T1: begin
				if (rd_data != cfd_pkg::TAIL1) begin
					adv = 1'b1;
				end else begin
					data_d  = '0;
					rd_off  = i6 + 6'd2;
					state_d = C2;
				end
			end
			C2: begin
				id_hi_d = rd_data;
				rd_off  = i6 + 6'd3;
				state_d = C3;
			end
			C3: begin
				can_id_d = {id_hi_q, rd_data[7:5]};
				if (dlc_q == 4'd0) begin
					state_d = EMIT;
				end else begin
					k_d     = '0;
					rd_off  = i6 + 6'd7;
					state_d = DAT;
				end
			end
			DAT: begin
				data_d[k_q] = rd_data;
				if ({1'b0, k_q} + 4'd1 == dlc_q) begin
					state_d = EMIT;
				end else begin
					k_d     = k_q + 1'b1;
					rd_off  = i6 + 6'd8 + cfd_pkg::OFF_W'(k_q);
					state_d = DAT;
				end
			end
			EMIT: begin
				if (out_free) begin
					push    = 1'b1;
					// drop the frame and everything before it, rescan from the front
					rd_off  = end6;
					head_d  = head_q + end6[cfd_pkg::PTR_W-1:0];
					count_d = count_q - end6[cfd_pkg::CNT_W-1:0];
					i_d     = '0;
					if (n6 == end6) begin
						state_d = IDLE;
					end else begin
						state_d = H0;
					end
				end
			end
			default: state_d = IDLE;
		endcase

		// rejected or non-header byte: next candidate one byte further on
		if (adv) begin
			i_d     = i_q + 1'b1;
			rd_off  = i6 + 1'b1;
			state_d = H0;
		end
		// candidate still waiting: trim the window so it starts there
		if (fin) begin
			head_d  = head_q + i_q;
			count_d = count_q - cfd_pkg::CNT_W'(i_q);
			state_d = IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= IDLE;
			head_q   <= '0;
			count_q  <= '0;
			i_q      <= '0;
			fl_q     <= '0;
			dlc_q    <= '0;
			k_q      <= '0;
			id_hi_q  <= '0;
			can_id_q <= '0;
			data_q   <= '0;
		end else begin
			state_q  <= state_d;
			head_q   <= head_d;
			count_q  <= count_d;
			i_q      <= i_d;
			fl_q     <= fl_d;
			dlc_q    <= dlc_d;
			k_q      <= k_d;
			id_hi_q  <= id_hi_d;
			can_id_q <= can_id_d;
			data_q   <= data_d;
		end
	end

endmodule

FILE: hdl/can_serial_frame_deframer.sv
// Flow: a byte is written in its accept cycle, then the window is walked at one RAM read
// per cycle, pausing while a result waits; a frame at the window front is checked at its header,
// id, length and tail, then its id and data bytes are read out, and m_tvalid rises once the output
// register takes it. No new byte is accepted until the walk after the last one ends; the single
// RAM read port sets this. A held result stalls the input when a new frame is ready, until taken.
// Reset: asynchronous, empties the window and the output register; RAM is not cleared.
// ----------------------------------------------------------------------------
// can_serial_frame_deframer
// Finds adapter frames in a serial byte stream and outputs id, length, data.
// ----------------------------------------------------------------------------
module can_serial_frame_deframer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] rx_byte
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [cfd_pkg::TDATA_W-1:0]   m_tdata    // [10:0] can_id, [14:11] data_length,
	                                                 // [22:15] data_0 .. [78:71] data_7, [79] 0
);

	logic             out_free;
	logic             push;
	cfd_pkg::result_t result;

	cfd_scanner u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.out_free(out_free),
		.push    (push),
		.result  (result)
	);

	cfd_out u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.result  (result),
		.out_free(out_free),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for can_serial_frame_deframer
// Streams serial bytes into the deframer, predicts decoded frames with a
// byte-window model, and checks every output transfer field by field.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [15:0] GOOD_TAIL  = {cfd_pkg::TAIL0, cfd_pkg::TAIL1};
	localparam int          DRAIN_TAIL = 200;   // covers a full rescan of the window
	localparam int          MAX_PRINTS = 40;

	typedef enum int {MATCH_NONE, MATCH_LONE_HDR, MATCH_PENDING, MATCH_FRAME} match_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [7:0]                   s_tdata = '0;
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [cfd_pkg::TDATA_W-1:0]  m_tdata;

	logic [7:0]        win_q[$];          // bytes the deframer still holds for its search
	cfd_pkg::result_t  pending_frames[$]; // decoded frames not yet seen on the output
	int                send_idle_pct = 0;
	int                recv_idle_pct = 0;
	int                hold_left = 0;
	int                bytes_sent = 0;
	int                frames_checked = 0;
	int                mismatch_count = 0;
	cfd_pkg::result_t  got_frame;
	cfd_pkg::result_t  want_frame;

	can_serial_frame_deframer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#10ms;
		$display("Some tests failed");
		$finish;
	end

	task automatic note_mismatch(input string what, input int got, input int want);
		if (mismatch_count < MAX_PRINTS)
			$display("%0t ns mismatch %s: got %0h expected %0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// ---- frame predictor ----

	function automatic void trim_window(input int k);
		repeat (k) begin
			if (win_q.size() != 0)
				void'(win_q.pop_front());
		end
	endfunction

	function automatic match_t find_frame(output int at, output int flen);
		int n;
		int dlc;
		n = win_q.size();
		at = 0;
		flen = 0;
		for (int i = 0; i < n; i++) begin
			if (win_q[i] != cfd_pkg::HDR0)
				continue;
			if (i + 1 >= n) begin
				at = i;
				return MATCH_LONE_HDR;
			end
			if (win_q[i+1] != cfd_pkg::HDR1)
				continue;
			// shortest frame not all in yet: hold the candidate
			if (i + 8 >= n) begin
				at = i;
				return MATCH_PENDING;
			end
			if ((win_q[i+5] & cfd_pkg::ID_REJECT) != 0)
				continue;
			dlc = win_q[i+6];
			if (dlc > cfd_pkg::MAX_DLC)
				continue;
			flen = 9 + dlc;
			if (i + flen > n) begin
				at = i;
				return MATCH_PENDING;
			end
			if (win_q[i+flen-2] != cfd_pkg::TAIL0 || win_q[i+flen-1] != cfd_pkg::TAIL1)
				continue;
			at = i;
			return MATCH_FRAME;
		end
		return MATCH_NONE;
	endfunction

	function automatic void absorb_byte(input logic [7:0] b);
		int                at;
		int                flen;
		match_t            m;
		cfd_pkg::result_t  r;
		if (win_q.size() >= cfd_pkg::WIN_DEPTH)
			void'(win_q.pop_front());
		win_q.push_back(b);
		m = find_frame(at, flen);
		if (m == MATCH_FRAME) begin
			r = '0;
			r.can_id      = {win_q[at+2], win_q[at+3][7:5]};
			r.data_length = win_q[at+6][3:0];
			for (int k = 0; k < 8; k++) begin
				if (k < win_q[at+6])
					r.data[k] = win_q[at+7+k];
			end
			pending_frames.push_back(r);
			trim_window(at + flen);
			m = find_frame(at, flen);
		end
		if (m == MATCH_NONE)
			win_q.delete();
		else
			trim_window(at);
	endfunction

	// ---- output side ----

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			hold_left <= 0;
		end else if (hold_left != 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_frame = m_tdata[$bits(cfd_pkg::result_t)-1:0];
			if (m_tdata[cfd_pkg::TDATA_W-1] !== 1'b0)
				note_mismatch("pad bit", m_tdata[cfd_pkg::TDATA_W-1], 0);
			if (pending_frames.size() == 0) begin
				note_mismatch("unexpected frame, can_id", got_frame.can_id, 0);
			end else begin
				want_frame = pending_frames.pop_front();
				if (got_frame.can_id !== want_frame.can_id)
					note_mismatch("can_id", got_frame.can_id, want_frame.can_id);
				if (got_frame.data_length !== want_frame.data_length)
					note_mismatch("data_length", got_frame.data_length,
						want_frame.data_length);
				for (int k = 0; k < 8; k++) begin
					if (got_frame.data[k] !== want_frame.data[k])
						note_mismatch($sformatf("data_%0d", k), got_frame.data[k],
							want_frame.data[k]);
				end
			end
			frames_checked++;
		end
	end

	// ---- input side ----

	task automatic push_byte(input logic [7:0] b);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		absorb_byte(b);
		bytes_sent++;
	endtask

	// fill < 0 gives random data; lengths past 8 still send only 8 data bytes
	task automatic send_frame(input logic [31:0] enc_id, input logic [7:0] dlc,
			input int fill, input logic [15:0] tail);
		push_byte(cfd_pkg::HDR0);
		push_byte(cfd_pkg::HDR1);
		push_byte(enc_id[31:24]);
		push_byte(enc_id[23:16]);
		push_byte(enc_id[15:8]);
		push_byte(enc_id[7:0]);
		push_byte(dlc);
		for (int k = 0; k < 8 && k < dlc; k++)
			push_byte(fill < 0 ? 8'($urandom) : fill[7:0]);
		push_byte(tail[15:8]);
		push_byte(tail[7:0]);
	endtask

	task automatic wait_results_drained();
		int guard;
		s_tvalid <= 1'b0;
		guard = 0;
		while (pending_frames.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	// ---- tests ----

	task automatic test_frame_extremes();
		send_frame(32'h0000_0000, 8'd0, 0, GOOD_TAIL);
		send_frame(32'hFFFF_FFFB, 8'd8, 255, GOOD_TAIL);
		send_frame(32'hA5C3_3C5A, 8'd8, cfd_pkg::HDR0, GOOD_TAIL);
		send_frame(32'h1234_5600, 8'd1, -1, GOOD_TAIL);
		wait_results_drained();
	endtask

	task automatic test_rejected_candidates();
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(cfd_pkg::HDR1);
		send_frame(32'h7654_3204, 8'd3, -1, GOOD_TAIL);     // id reject bit set
		send_frame(32'h7654_3200, 8'd9, -1, GOOD_TAIL);     // length past eight
		send_frame(32'h7654_3200, 8'hFF, -1, GOOD_TAIL);
		send_frame(32'h7654_3200, 8'd2, -1, {cfd_pkg::TAIL1, cfd_pkg::TAIL0}); // swapped tail
		send_frame(32'hCAFE_0011, 8'd4, -1, GOOD_TAIL);
		// lone header byte left hanging, then a frame right behind it
		push_byte(cfd_pkg::HDR0);
		wait_results_drained();
		send_frame(32'h0BAD_F00D & ~32'h4, 8'd5, -1, GOOD_TAIL);
		wait_results_drained();
	endtask

	task automatic test_nested_candidate();
		// outer header sees the inner id byte with bit 2 set, so the inner frame wins
		push_byte(cfd_pkg::HDR0);
		push_byte(cfd_pkg::HDR1);
		send_frame(32'h12_0F_99_20, 8'd6, -1, GOOD_TAIL);
		push_byte(cfd_pkg::TAIL0);                           // trailing bytes after a frame
		push_byte(cfd_pkg::HDR0);
		send_frame(32'h00_00_00_03, 8'd7, cfd_pkg::HDR1, GOOD_TAIL);
		wait_results_drained();
	endtask

	task automatic test_backpressure();
		logic [31:0] enc;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_left <= 400;
		repeat (12) begin
			enc = $urandom;
			enc[2] = 1'b0;
			send_frame(enc, 8'($urandom_range(8)), -1, GOOD_TAIL);
		end
		wait_results_drained();
	endtask

	task automatic test_random_traffic(input int send_pct, input int recv_pct,
			input int n_bytes);
		int          stop_at;
		int          pick;
		logic [31:0] enc;
		logic [7:0]  dlc;
		logic [7:0]  b;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at) begin
			pick = $urandom_range(99);
			enc = $urandom;
			enc[2] = 1'b0;
			dlc = $urandom_range(8);
			if (pick < 72) begin
				send_frame(enc, dlc, -1, GOOD_TAIL);
			end else if (pick < 78) begin
				enc[2] = 1'b1;
				send_frame(enc, dlc, -1, GOOD_TAIL);
			end else if (pick < 83) begin
				send_frame(enc, 8'($urandom_range(255, 9)), -1, GOOD_TAIL);
			end else if (pick < 88) begin
				send_frame(enc, dlc, -1, 16'($urandom));
			end else if (pick < 92) begin
				// header cut short, followed by whatever comes next
				push_byte(cfd_pkg::HDR0);
				push_byte(cfd_pkg::HDR1);
				repeat ($urandom_range(6)) push_byte(8'($urandom));
			end else begin
				repeat ($urandom_range(6, 1)) begin
					case ($urandom_range(4))
						0: b = cfd_pkg::HDR0;
						1: b = cfd_pkg::HDR1;
						2: b = cfd_pkg::TAIL0;
						3: b = cfd_pkg::TAIL1;
						default: b = 8'($urandom);
					endcase
					push_byte(b);
				end
			end
		end
		wait_results_drained();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 21;
		recv_idle_pct = 66;
		test_frame_extremes();
		test_rejected_candidates();
		test_nested_candidate();
		test_backpressure();
		test_random_traffic(21, 66, 350);
		test_random_traffic(66, 21, 350);
		test_random_traffic(0, 0, 350);

		while (pending_frames.size() != 0) begin
			want_frame = pending_frames.pop_front();
			note_mismatch("missing frame, can_id", 0, want_frame.can_id);
		end

		$display("Covered %0d input bytes and %0d decoded frames across rejects,",
			bytes_sent, frames_checked);
		$display("nested headers, output stalls and three idle mixes.");
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: can_serial_frame_deframer.f
hdl/cfd_pkg.sv
hdl/cfd_ram.sv
hdl/cfd_out.sv
hdl/cfd_scanner.sv
hdl/can_serial_frame_deframer.sv
tb/tb.sv
